[rtl/core/spq_pkg.sv]
// Shared types, codes and constants of the stable min-priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Fixed widths of the request and response fields.
  localparam int ID_W     = 16;
  localparam int PRI_W    = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 8;

  // Default configuration of the queue.
  localparam int DEFAULT_QUEUE_DEPTH   = 128;
  localparam int DEFAULT_ID_BITS       = 16;
  localparam int DEFAULT_PRIORITY_BITS = 8;

  // Request action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic             action;
    logic [ID_W-1:0]  entry_id;
    logic [PRI_W-1:0] entry_priority;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]     out_id;
    logic [PRI_W-1:0]    out_priority;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  // Which logical slot the storage read port looks at.
  typedef enum logic [1:0] {
    RD_HEAD  = 2'd0,
    RD_PREV  = 2'd1,
    RD_PREV2 = 2'd2
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_req;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                shift;
    logic                place;
    logic                pop;
    logic                rsp_load;
    logic                rsp_with_data;
    logic [STATUS_W-1:0] rsp_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_insert;
    logic full;
    logic empty;
    logic pos_zero;
    logic pos_one;
    logic greater;
    logic rsp_free;
  } sts_t;

endpackage

[rtl/core/spq_chan_if.sv]
// Valid/ready channel interface carrying one request or response payload.
`timescale 1ns / 1ps

interface spq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/spq_ctrl.sv]
// Controller state machine of the stable min-priority queue.
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DECIDE  = 5'b00010,
    S_CMP     = 5'b00100,
    S_PLACE   = 5'b01000,
    S_REM_OUT = 5'b10000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    cmd               = '0;
    cmd.rd_sel        = RD_HEAD;
    cmd.rsp_code      = ST_DONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_insert) begin
          if (sts.full) begin
            if (sts.rsp_free) begin
              cmd.rsp_load = 1'b1;
              cmd.rsp_code = ST_FULL;
              state_next   = S_IDLE;
            end
          end else if (sts.pos_zero) begin
            state_next = S_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PREV;
            state_next = S_CMP;
          end
        end else begin
          if (sts.empty) begin
            if (sts.rsp_free) begin
              cmd.rsp_load = 1'b1;
              cmd.rsp_code = ST_EMPTY;
              state_next   = S_IDLE;
            end
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HEAD;
            state_next = S_REM_OUT;
          end
        end
      end
      S_CMP: begin
        // The read data is the entry just below the open slot.
        if (sts.greater) begin
          cmd.shift = 1'b1;
          if (sts.pos_one) begin
            state_next = S_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PREV2;
          end
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        if (sts.rsp_free) begin
          cmd.place    = 1'b1;
          cmd.rsp_load = 1'b1;
          cmd.rsp_code = ST_DONE;
          state_next   = S_IDLE;
        end
      end
      S_REM_OUT: begin
        if (sts.rsp_free) begin
          cmd.pop           = 1'b1;
          cmd.rsp_load      = 1'b1;
          cmd.rsp_with_data = 1'b1;
          cmd.rsp_code      = ST_DONE;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/spq_datapath.sv]
// Datapath of the stable min-priority queue: slot memory, pointers and response register.
`timescale 1ns / 1ps

module spq_datapath import spq_pkg::*; #(
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
  parameter int ID_BITS       = DEFAULT_ID_BITS,
  parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
  input  logic clk,
  input  logic rst,
  input  req_t req_data,
  input  logic rsp_ready,
  output logic rsp_valid,
  output rsp_t rsp_data,
  input  cmd_t cmd,
  output sts_t sts
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = AW + 2;
  localparam int SIDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int SPW  = (PRIORITY_BITS < PRI_W) ? PRIORITY_BITS : PRI_W;

  typedef struct packed {
    logic [SIDW-1:0] id;
    logic [SPW-1:0]  pri;
  } slot_t;

  slot_t mem [QUEUE_DEPTH];

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] pos;
  logic          is_insert;
  slot_t         new_slot;
  slot_t         rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // Logical slot to physical address in the circular store; the sum stays
  // below twice the depth, so one conditional subtract wraps it.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(l);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD:  rd_addr = head;
      RD_PREV:  rd_addr = phys(head, pos - CW'(1));
      RD_PREV2: rd_addr = phys(head, pos - CW'(2));
      default:  rd_addr = head;
    endcase
  end

  assign wr_addr = phys(head, pos);

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      mem[wr_addr] <= rd_data;
    end else if (cmd.place) begin
      mem[wr_addr] <= new_slot;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.place) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (cmd.pop) begin
        head <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      is_insert    <= (req_data.action == ACT_INSERT);
      new_slot.id  <= req_data.entry_id[SIDW-1:0];
      new_slot.pri <= req_data.entry_priority[SPW-1:0];
      pos          <= count;
    end else if (cmd.shift) begin
      pos <= pos - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp_data.out_id       <= cmd.rsp_with_data ? ID_W'(rd_data.id) : '0;
      rsp_data.out_priority <= cmd.rsp_with_data ? PRI_W'(rd_data.pri) : '0;
      rsp_data.status       <= cmd.rsp_code;
      rsp_data.occupancy    <= OCC_W'(count_next);
    end
  end

  assign sts.is_insert = is_insert;
  assign sts.full      = (count == CW'(QUEUE_DEPTH));
  assign sts.empty     = (count == '0);
  assign sts.pos_zero  = (pos == '0);
  assign sts.pos_one   = (pos == CW'(1));
  assign sts.greater   = (rd_data.pri > new_slot.pri);
  assign sts.rsp_free  = !rsp_valid || rsp_ready;

endmodule

[rtl/core/stable_min_priority_queue.sv]
// Top level of the stable min-priority queue.
//
// A bounded priority queue of QUEUE_DEPTH entries kept sorted by priority
// number, lowest first; entries of equal priority leave in the order they
// arrived. Each request on the req channel either inserts an id and a
// priority or removes the head entry, and each request yields exactly one
// response on the rsp channel with the removed entry (zero for inserts),
// a status (done, insert dropped because full, or remove found the queue
// empty) and the occupancy after the request. Entries sit in a circular
// memory with one read and one write port and a head pointer. A remove
// reads the head entry and then answers with it. An insert walks from the
// tail toward the head, moving one stored entry up per cycle for each entry
// whose priority number is greater than the new one; the memory's one write
// and one read port set that pace. An insert into a full queue or a remove
// from an empty queue answers without a memory access. One request is
// worked on at a time; a new request is taken as soon as the previous one
// has placed its response in the output register, even while that response
// still waits to be taken. No clearing pass runs after reset.
`timescale 1ns / 1ps

module stable_min_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
  parameter int ID_BITS       = DEFAULT_ID_BITS,
  parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
  input logic        clk,
  input logic        rst,
  spq_chan_if.sink   req,
  spq_chan_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each request; it only sees status flags.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the slots, the head pointer, the entry count and the
  // response register that decouples the two channels.
  spq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.payload),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp_data  (rsp.payload),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[rtl/core/spq_checker.sv]
// Port-level assertions for the stable min-priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_payload
);

  // No response may appear straight out of reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // A response that waits keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("stalled response changed");

  // Only a successful remove carries an entry.
  a_no_data_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.status != ST_DONE |->
      rsp_payload.out_id == '0 && rsp_payload.out_priority == '0)
    else $error("failed request returned entry data");

  // A dropped insert reports the queue at full depth.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.status == ST_FULL |->
      rsp_payload.occupancy == OCC_W'(QUEUE_DEPTH))
    else $error("full status with wrong occupancy");

  // Every response has a legal status code, and an empty remove reports zero occupancy.
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_payload.status == ST_DONE || rsp_payload.status == ST_FULL ||
                   (rsp_payload.status == ST_EMPTY && rsp_payload.occupancy == '0)))
    else $error("bad status or empty status with nonzero occupancy");

endmodule

bind stable_min_priority_queue spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

[tb/sv/spq_order_check.sv]
// Checker that predicts and compares every response of the stable min-priority queue.
`timescale 1ns / 1ps

module spq_order_check import spq_pkg::*; #(
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
  parameter int ID_BITS       = DEFAULT_ID_BITS,
  parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_payload,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_payload,
  output int   mismatches,
  output int   pending
);

  localparam logic [ID_W-1:0]  ID_MASK  = ID_W'((64'd1 << ID_BITS) - 1);
  localparam logic [PRI_W-1:0] PRI_MASK = PRI_W'((64'd1 << PRIORITY_BITS) - 1);

  // Image of the sorted store: slot 0 is the head.
  logic [ID_W-1:0]  image_ids [QUEUE_DEPTH];
  logic [PRI_W-1:0] image_pri [QUEUE_DEPTH];
  int               image_count;

  rsp_t awaited_rsps[$];
  int   rsp_seen;

  // Applies one request to the image and returns the response it must produce.
  function automatic rsp_t advance_queue_image(input req_t r);
    rsp_t             res;
    int               pos;
    int               k;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    res = '0;
    res.status = ST_DONE;
    id  = r.entry_id & ID_MASK;
    pri = r.entry_priority & PRI_MASK;
    if (r.action == ACT_INSERT) begin
      if (image_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // Equal priorities stay ahead of the new entry, so ties leave in arrival order.
        pos = image_count;
        while (pos > 0 && image_pri[pos-1] > pri) begin
          image_ids[pos] = image_ids[pos-1];
          image_pri[pos] = image_pri[pos-1];
          pos--;
        end
        image_ids[pos] = id;
        image_pri[pos] = pri;
        image_count++;
      end
    end else if (image_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.out_id       = image_ids[0];
      res.out_priority = image_pri[0];
      for (k = 1; k < image_count; k++) begin
        image_ids[k-1] = image_ids[k];
        image_pri[k-1] = image_pri[k];
      end
      image_count--;
    end
    res.occupancy = OCC_W'(image_count);
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      image_count = 0;
      awaited_rsps.delete();
      mismatches = 0;
      rsp_seen = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d arrived with no request outstanding: id=%h pri=%h status=%0d occ=%0d",
                     rsp_seen, rsp_payload.out_id, rsp_payload.out_priority,
                     rsp_payload.status, rsp_payload.occupancy);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_payload.out_id !== want.out_id ||
              rsp_payload.out_priority !== want.out_priority ||
              rsp_payload.status !== want.status ||
              rsp_payload.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response %0d: expected id=%h pri=%h status=%0d occ=%0d, got id=%h pri=%h status=%0d occ=%0d",
                       rsp_seen, want.out_id, want.out_priority, want.status, want.occupancy,
                       rsp_payload.out_id, rsp_payload.out_priority,
                       rsp_payload.status, rsp_payload.occupancy);
          end
        end
        rsp_seen++;
      end
      // A response is always registered after its request was accepted, so the
      // order of these two checks within one edge does not matter.
      if (req_valid && req_ready)
        awaited_rsps.push_back(advance_queue_image(req_payload));
    end
    pending = awaited_rsps.size();
  end

endmodule

[tb/sv/stable_min_priority_queue_tb.sv]
// Top of the testbench: clock, reset, request and response traffic, and the verdict.
`timescale 1ns / 1ps

module stable_min_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
  localparam int RANDOM_ITEMS = 1430;
  // The response side stops taking responses once this many have been taken,
  // and then holds off for HOLD_CYCLES so that the request side backs up.
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 600;
  // Wait at the end for longer than an insert that passes every stored entry
  // takes, to catch stray responses.
  localparam int DRAIN_CYCLES = 200;

  // How the priorities of one stretch of random requests are drawn.
  typedef enum int {
    PRI_ANY,   // the whole range
    PRI_FEW,   // a handful of values, so ties are common
    PRI_EDGE   // mostly the two extremes
  } pri_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   pending;
  int   send_calm;

  spq_chan_if #(.payload_t(req_t)) req_if ();
  spq_chan_if #(.payload_t(rsp_t)) rsp_if ();

  stable_min_priority_queue #(
    .QUEUE_DEPTH  (DEPTH),
    .ID_BITS      (DEFAULT_ID_BITS),
    .PRIORITY_BITS(DEFAULT_PRIORITY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  spq_order_check #(
    .QUEUE_DEPTH  (DEPTH),
    .ID_BITS      (DEFAULT_ID_BITS),
    .PRIORITY_BITS(DEFAULT_PRIORITY_BITS)
  ) u_order_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_if.valid),
    .req_ready  (req_if.ready),
    .req_payload(req_if.payload),
    .rsp_valid  (rsp_if.valid),
    .rsp_ready  (rsp_if.ready),
    .rsp_payload(rsp_if.payload),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a response.
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Idle length before the next request or response. Most gaps are short and
  // a few are long; now and then a stretch of back-to-back transfers starts,
  // tracked through calm_left.
  function automatic int pick_gap(inout int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [PRI_W-1:0] pick_priority(input pri_mix_t mix);
    case (mix)
      PRI_FEW:  return PRI_W'($urandom_range(0, 3));
      PRI_EDGE: begin
        if ($urandom_range(0, 3) == 0)
          return PRI_W'($urandom);
        return $urandom_range(0, 1) ? {PRI_W{1'b1}} : {PRI_W{1'b0}};
      end
      default:  return PRI_W'($urandom);
    endcase
  endfunction

  // Offers one request, starting at a falling edge, and returns at the falling
  // edge after it was taken. Valid stays high between back-to-back requests.
  task automatic send_request(input logic act, input logic [ID_W-1:0] id,
                              input logic [PRI_W-1:0] pri);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.payload <= req_t'{action: act, entry_id: id, entry_priority: pri};
    req_if.valid   <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // Response side: takes responses with random gaps, and once holds off for a
  // long stretch while the request side keeps offering, so the block stalls.
  initial begin : response_sink
    int taken;
    int gap;
    int calm;
    taken = 0;
    calm = 0;
    rsp_if.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = pick_gap(calm);
      if (taken == HOLD_AFTER)
        gap = HOLD_CYCLES;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : request_source
    int       sent;
    int       span;
    int       insert_pct;
    bit       first_phase;
    pri_mix_t mix;
    send_calm = 0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A remove on an empty queue comes first.
    send_request(ACT_REMOVE, 16'h0000, 8'h00);
    // Field extremes, the lowest priority going in first so later ones pass it.
    send_request(ACT_INSERT, 16'hFFFF, 8'hFF);
    send_request(ACT_INSERT, 16'h0000, 8'h00);
    // Three entries of equal priority must leave in arrival order.
    send_request(ACT_INSERT, 16'h1234, 8'h80);
    send_request(ACT_INSERT, 16'h1235, 8'h80);
    send_request(ACT_INSERT, 16'h1236, 8'h80);
    send_request(ACT_INSERT, 16'hA5A5, 8'h7F);
    // Ties with the entries at both ends of the store.
    send_request(ACT_INSERT, 16'h5A5A, 8'hFF);
    send_request(ACT_INSERT, 16'h0F0F, 8'h00);
    // A remove carries ignored fields; give them all ones.
    send_request(ACT_REMOVE, 16'hFFFF, 8'hFF);
    send_request(ACT_INSERT, 16'hC3C3, 8'h01);
    // Drain the queue and go one past empty.
    repeat (9) send_request(ACT_REMOVE, 16'h0000, 8'h00);

    // Random part in stretches, each with its own mix of inserts and removes.
    // The first stretch only inserts, so the queue is sure to fill and drop.
    sent = 0;
    first_phase = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (first_phase) begin
        insert_pct = 100;
        span = DEPTH + 12;
        mix = PRI_ANY;
        first_phase = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 90;
          1:       insert_pct = 15;
          2:       insert_pct = 50;
          default: insert_pct = 60;
        endcase
        span = $urandom_range(40, 160);
        mix = pri_mix_t'($urandom_range(0, 2));
      end
      repeat (span) begin
        if (sent < RANDOM_ITEMS) begin
          if ($urandom_range(0, 99) < insert_pct)
            send_request(ACT_INSERT, ID_W'($urandom), pick_priority(mix));
          else
            send_request(ACT_REMOVE, ID_W'($urandom), PRI_W'($urandom));
          sent++;
        end
      end
    end
    req_if.valid <= 1'b0;

    // Wait for every outstanding response, then a while longer for strays.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/spq_pkg.sv
rtl/core/spq_chan_if.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/stable_min_priority_queue.sv
rtl/core/spq_checker.sv
tb/sv/spq_order_check.sv
tb/sv/stable_min_priority_queue_tb.sv
